// File: sv/command_frame_receiver_unit_defines.svh
// Assertion macros shared by the command frame receiver RTL.
// Needs aclk and aresetn in scope at the point of use.
`ifndef COMMAND_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge out of reset
`define CFR_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("cfr assertion failed");
// consequent must hold in the same cycle as the antecedent
`define CFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cfr assertion failed");
// consequent must hold in the cycle after the antecedent
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cfr assertion failed");
`else
`define CFR_ASSERT(label, cond)
`define CFR_ASSERT_IMP(label, ante, cons)
`define CFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/cfr_pkg.sv
// Package for the command frame receiver: widths, codes and parser states.
// No dependencies; imported by command_frame_receiver_unit.
`timescale 1ns / 1ps

package cfr_pkg;

    localparam int BYTE_W        = 8;
    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAYLOAD_AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int CFG_INDEX_W   = 2;
    localparam int EVENT_W       = 3;
    localparam int S_TDATA_W     = 2 * BYTE_W;
    localparam int M_TDATA_W     = 3 * BYTE_W;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'h55;
    localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'hAA;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_TAIL_FIRST    = 2'd2,
        CFG_TAIL_SECOND   = 2'd3
    } cfg_reg_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_OK       = 3'd1,
        EV_BAD_HDR2 = 3'd2,
        EV_BAD_SUM  = 3'd3,
        EV_BAD_T1   = 3'd4,
        EV_BAD_T2   = 3'd5
    } event_t;

    typedef enum logic [7:0] {
        ST_HEAD1 = 8'b0000_0001,
        ST_HEAD2 = 8'b0000_0010,
        ST_CMD   = 8'b0000_0100,
        ST_LEN   = 8'b0000_1000,
        ST_DATA  = 8'b0001_0000,
        ST_SUM   = 8'b0010_0000,
        ST_TAIL1 = 8'b0100_0000,
        ST_TAIL2 = 8'b1000_0000
    } parse_state_t;

endpackage

// File: sv/command_frame_receiver_unit.sv
// Command frame receiver: byte-stream deframer with additive checksum and payload store.
// Depends on cfr_pkg and command_frame_receiver_unit_defines.svh.
`timescale 1ns / 1ps
`include "command_frame_receiver_unit_defines.svh"

// Each transfer on the s_ side either feeds one received byte to the frame parser
// (tuser 0) or reads one stored payload byte (tuser 1), and yields exactly one
// transfer on the m_ side. A frame is header_first, header_second, command,
// length, length payload bytes, checksum (sum of command, length and payload mod
// 256), tail_first, tail_second. The m_ transfer carries an event code: frame ok
// with its command and length, or bad second header, bad checksum, bad first
// tail, bad second tail, each of which restarts the parser. Unmatched bytes while
// a first header is awaited are dropped with event none. One transfer is taken
// every cycle while the m_ side is not stalled; a result passes through the
// registered read port of the payload memory and then the output register.
// Reading a payload position never written in a frame returns an unspecified
// byte. Header and tail bytes are set through the cfg_ write port; cfg_ready is always
// high. The user must write them only while no transfer is in flight; not enforced.
module command_frame_receiver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: rx_byte [7:0], read_index [15:8]
    input  logic [cfr_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: func [0]
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: frame_command [7:0], frame_length [15:8], read_data [23:16]
    output logic [cfr_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: event_res [2:0]
    output logic [cfr_pkg::EVENT_W-1:0]       m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cfr_pkg::BYTE_W-1:0]        cfg_data
);
    import cfr_pkg::*;

    // configuration
    logic [BYTE_W-1:0] header_first_reg, header_second_reg;
    logic [BYTE_W-1:0] tail_first_reg, tail_second_reg;

    // parser state
    parse_state_t      state_reg, state_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] position_reg, position_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    // memory read stage
    logic              p_valid_reg;
    logic              p_func_reg;
    logic              p_rd_ok_reg;
    event_t            p_event_reg, p_event_next;
    logic [BYTE_W-1:0] p_cmd_reg, p_cmd_next;
    logic [BYTE_W-1:0] p_len_reg, p_len_next;
    logic [BYTE_W-1:0] ram_q_reg;

    // output register
    logic              out_valid_reg;
    event_t            out_event_reg;
    logic [BYTE_W-1:0] out_cmd_reg, out_len_reg, out_rd_reg;

    logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];

    logic              s_func;
    logic [BYTE_W-1:0] rx_byte, read_index;
    logic              accept, p_advance, byte_accept;
    logic              store_we, rd_ok;
    logic [BYTE_W-1:0] sum_plus_byte, position_inc;

    assign s_func     = s_tuser;
    assign rx_byte    = s_tdata[BYTE_W-1:0];
    assign read_index = s_tdata[2*BYTE_W-1:BYTE_W];

    assign p_advance   = p_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready    = !p_valid_reg || p_advance;
    assign accept      = s_tvalid && s_tready;
    assign byte_accept = accept && !s_func;
    assign cfg_ready   = 1'b1;

    assign sum_plus_byte = sum_reg + rx_byte;
    assign position_inc  = position_reg + 8'd1;
    assign rd_ok    = ({1'b0, read_index} < (BYTE_W+1)'(PAYLOAD_DEPTH));
    assign store_we = byte_accept && (state_reg == ST_DATA)
                      && ({1'b0, position_reg} < (BYTE_W+1)'(PAYLOAD_DEPTH));

    always_comb begin
        state_next    = state_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        position_next = position_reg;
        sum_next      = sum_reg;
        p_event_next  = EV_NONE;
        p_cmd_next    = '0;
        p_len_next    = '0;
        case (state_reg)
            ST_HEAD1: begin
                if (rx_byte == header_first_reg) begin
                    state_next = ST_HEAD2;
                end
            end
            ST_HEAD2: begin
                if (rx_byte == header_second_reg) begin
                    state_next = ST_CMD;
                end else begin
                    p_event_next = EV_BAD_HDR2;
                    state_next   = ST_HEAD1;
                end
            end
            ST_CMD: begin
                command_next = rx_byte;
                sum_next     = rx_byte;
                state_next   = ST_LEN;
            end
            ST_LEN: begin
                length_next   = rx_byte;
                sum_next      = sum_plus_byte;
                position_next = '0;
                state_next    = (rx_byte == '0) ? ST_SUM : ST_DATA;
            end
            ST_DATA: begin
                sum_next      = sum_plus_byte;
                position_next = position_inc;
                if (position_inc == length_reg) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (rx_byte == sum_reg) begin
                    state_next = ST_TAIL1;
                end else begin
                    p_event_next = EV_BAD_SUM;
                    state_next   = ST_HEAD1;
                end
            end
            ST_TAIL1: begin
                if (rx_byte == tail_first_reg) begin
                    state_next = ST_TAIL2;
                end else begin
                    p_event_next = EV_BAD_T1;
                    state_next   = ST_HEAD1;
                end
            end
            ST_TAIL2: begin
                if (rx_byte == tail_second_reg) begin
                    p_event_next = EV_OK;
                    p_cmd_next   = command_reg;
                    p_len_next   = length_reg;
                end else begin
                    p_event_next = EV_BAD_T2;
                end
                state_next = ST_HEAD1;
            end
            default: begin
                state_next = ST_HEAD1;
            end
        endcase
        // any return to the first header clears holds, position and sum
        if (state_reg != ST_HEAD1 && state_next == ST_HEAD1) begin
            command_next  = '0;
            length_next   = '0;
            position_next = '0;
            sum_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= HEADER_FIRST_RST;
            header_second_reg <= HEADER_SECOND_RST;
            tail_first_reg    <= TAIL_FIRST_RST;
            tail_second_reg   <= TAIL_SECOND_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                CFG_HEADER_SECOND: header_second_reg <= cfg_data;
                CFG_TAIL_FIRST:    tail_first_reg    <= cfg_data;
                CFG_TAIL_SECOND:   tail_second_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HEAD1;
            command_reg  <= '0;
            length_reg   <= '0;
            position_reg <= '0;
            sum_reg      <= '0;
        end else if (byte_accept) begin
            state_reg    <= state_next;
            command_reg  <= command_next;
            length_reg   <= length_next;
            position_reg <= position_next;
            sum_reg      <= sum_next;
        end
    end

    // payload store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (store_we) begin
            payload_mem[position_reg[PAYLOAD_AW-1:0]] <= rx_byte;
        end
        if (accept) begin
            ram_q_reg <= payload_mem[read_index[PAYLOAD_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= 1'b1;
        end else if (p_advance) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_func_reg  <= s_func;
            p_rd_ok_reg <= rd_ok;
            p_event_reg <= s_func ? EV_NONE : p_event_next;
            p_cmd_reg   <= s_func ? '0 : p_cmd_next;
            p_len_reg   <= s_func ? '0 : p_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p_advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_advance) begin
            out_event_reg <= p_event_reg;
            out_cmd_reg   <= p_cmd_reg;
            out_len_reg   <= p_len_reg;
            out_rd_reg    <= (p_func_reg && p_rd_ok_reg) ? ram_q_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {out_rd_reg, out_len_reg, out_cmd_reg};

    // a result with an event never carries read data
    `CFR_ASSERT_IMP(a_event_no_read, m_tvalid && (m_tuser != EV_NONE), out_rd_reg == '0)
    // command and length only accompany a good frame
    `CFR_ASSERT_IMP(a_cmd_only_ok, m_tvalid && ((out_cmd_reg != '0) || (out_len_reg != '0)),
                    m_tuser == EV_OK)
    // the second tail byte always returns the parser to the first header
    `CFR_ASSERT_NEXT(a_tail2_restart, byte_accept && (state_reg == ST_TAIL2),
                     (state_reg == ST_HEAD1) && (sum_reg == '0))
    // a finished read stage with an empty output register always moves on
    `CFR_ASSERT_NEXT(a_stage_moves, p_valid_reg && !out_valid_reg, out_valid_reg)

endmodule
